/* sv/swmf_pkg.sv */
// Shared types and constants for the sliding-window median filter.
`default_nettype none

package swmf_pkg;

  localparam int DIST_W  = 16;
  localparam int ANGLE_W = 16;
  localparam int CNT_W   = 5;
  localparam int WORD_W  = DIST_W + ANGLE_W;

  localparam logic [CNT_W-1:0] WSIZE_RESET = 5'd16;

  // distance in the upper half so that equality and ordering match the sorted list
  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [ANGLE_W-1:0] angle;
  } reading_t;

  typedef struct packed {
    logic     start;
    logic     clear;
    logic     out_free;
    reading_t entry;
  } eng_req_t;

  typedef struct packed {
    logic             idle;
    logic             done;
    reading_t         med;
    logic [CNT_W-1:0] held;
  } eng_status_t;

endpackage

`default_nettype wire

/* sv/sliding_window_median_filter_core.sv */
// Top level: stream ports, window size register, result register.
//
//  channel   dir  handshake          payload
//  s_*       in   s_tvalid/s_tready  tdata: distance[15:0], angle[31:16]
//  m_*       out  m_tvalid/m_tready  tdata: median_distance[15:0],
//                                           median_angle[31:16], fill_count[36:32]
//  cfg_*     in   cfg_we             cfg_wdata: window_size[4:0]
//
// While the window fills, each word moves the new reading k >= 1 places left,
// else k places right (k may be 0). Once full, each word first searches the
// sorted list for the oldest reading, over s entries (1 up to the window size).
// Both walks use the single read port of the sorted-list RAM.
// s_tready is high only while the sequencer is idle; a held result does not
// block input until the next one is ready to leave. Reset and any window size
// write empty the window.
`default_nettype none

module sliding_window_median_filter_core
  import swmf_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output      logic             s_tready,
  input  wire logic [31:0]      s_tdata,   // distance, angle
  output      logic             m_tvalid,
  input  wire logic             m_tready,
  output      logic [39:0]      m_tdata,   // median_distance, median_angle, fill_count
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata  // window_size
);

  logic [CNT_W-1:0] window_size;
  logic [CNT_W-1:0] cap;
  eng_req_t         req;
  eng_status_t      status;

  always_comb begin
    if (window_size == '0) begin
      cap = 5'd1;
    end else if (int'(window_size) > WINDOW_MAX) begin
      cap = 5'(WINDOW_MAX);
    end else begin
      cap = window_size;
    end
  end

  assign s_tready           = status.idle;
  assign req.start          = s_tvalid && s_tready;
  assign req.clear          = cfg_we;
  assign req.out_free       = !m_tvalid || m_tready;
  assign req.entry.distance = s_tdata[15:0];
  assign req.entry.angle    = s_tdata[31:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size <= cfg_wdata;
      end
      if (status.done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (status.done) begin
      m_tdata <= {3'b000, status.held, status.med.angle, status.med.distance};
    end
  end

  swmf_engine #(.WINDOW_MAX(WINDOW_MAX)) u_engine (
    .clk    (clk),
    .rst    (rst),
    .cap    (cap),
    .req    (req),
    .status (status)
  );

endmodule

`default_nettype wire

/* sv/swmf_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module swmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                     wr_data,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output      logic [WIDTH-1:0]                     rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

/* sv/swmf_engine.sv */
// Sequencer and compare unit that walks the arrival ring and the sorted list.
`default_nettype none

module swmf_engine
  import swmf_pkg::*;
#(
  parameter int WINDOW_MAX = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [CNT_W-1:0] cap,
  input  wire eng_req_t         req,
  output      eng_status_t      status
);

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_OLD    = 9'b000000010,
    S_SEARCH = 9'b000000100,
    S_PLACE  = 9'b000001000,
    S_LEFT   = 9'b000010000,
    S_RIGHT  = 9'b000100000,
    S_WRITE  = 9'b001000000,
    S_MED    = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t           state, state_next;
  reading_t         entry;
  reading_t         oldest;
  logic [IDX_W-1:0] idx, idx_next;
  logic [IDX_W-1:0] scan;
  logic [IDX_W-1:0] wp;
  logic [CNT_W-1:0] held;
  logic             moved;

  logic [IDX_W-1:0] srt_rd_addr, srt_wr_addr;
  logic             srt_we;
  reading_t         srt_wr_data, srt_rd_data;
  reading_t         ring_rd_data;
  logic             ring_we;

  logic left_move, right_move;

  assign left_move  = (idx != '0) && (entry.distance < srt_rd_data.distance);
  assign right_move = ((int'(idx) + 1) < int'(held)) &&
                      (entry.distance > srt_rd_data.distance);

  assign ring_we = (state == S_PLACE);

  // read address is issued in the cycle before the compare that uses it
  always_comb begin
    state_next  = state;
    idx_next    = idx;
    srt_rd_addr = '0;
    srt_we      = 1'b0;
    srt_wr_addr = idx;
    srt_wr_data = entry;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          if (held < cap) begin
            idx_next   = IDX_W'(held);
            state_next = S_PLACE;
          end else begin
            state_next = S_OLD;
          end
        end
      end
      S_OLD: begin
        idx_next    = IDX_W'(cap - 5'd1);
        srt_rd_addr = '0;
        state_next  = S_SEARCH;
      end
      S_SEARCH: begin
        srt_rd_addr = scan + IDX_W'(1);
        if (srt_rd_data == oldest) begin
          idx_next   = scan;
          state_next = S_PLACE;
        end else if (int'(scan) + 1 >= int'(cap)) begin
          state_next = S_PLACE;
        end
      end
      S_PLACE: begin
        srt_rd_addr = idx - IDX_W'(1);
        state_next  = S_LEFT;
      end
      S_LEFT: begin
        if (left_move) begin
          srt_we      = 1'b1;
          srt_wr_data = srt_rd_data;
          idx_next    = idx - IDX_W'(1);
          srt_rd_addr = idx - IDX_W'(2);
        end else if (moved) begin
          state_next = S_WRITE;
        end else begin
          srt_rd_addr = idx + IDX_W'(1);
          state_next  = S_RIGHT;
        end
      end
      S_RIGHT: begin
        srt_rd_addr = idx + IDX_W'(2);
        if (right_move) begin
          srt_we      = 1'b1;
          srt_wr_data = srt_rd_data;
          idx_next    = idx + IDX_W'(1);
        end else begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        srt_we     = 1'b1;
        state_next = S_MED;
      end
      S_MED: begin
        srt_rd_addr = IDX_W'(held >> 1);
        state_next  = S_OUT;
      end
      S_OUT: begin
        srt_rd_addr = IDX_W'(held >> 1);
        if (req.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
      wp    <= '0;
      moved <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (req.clear) begin
        held <= '0;
        wp   <= '0;
      end
      case (state)
        S_IDLE: begin
          moved <= 1'b0;
          if (req.start) begin
            entry <= req.entry;
            if (held < cap) begin
              held <= held + 5'd1;
            end
          end
        end
        S_OLD: begin
          oldest <= ring_rd_data;
          scan   <= '0;
        end
        S_SEARCH: begin
          scan <= scan + IDX_W'(1);
        end
        S_PLACE: begin
          if (int'(wp) + 1 >= int'(cap)) begin
            wp <= '0;
          end else begin
            wp <= wp + IDX_W'(1);
          end
        end
        S_LEFT: begin
          if (left_move) begin
            moved <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  swmf_ram #(.WIDTH(WORD_W), .DEPTH(WINDOW_MAX)) u_ring (
    .clk     (clk),
    .we      (ring_we),
    .wr_addr (wp),
    .wr_data (entry),
    .rd_addr (wp),
    .rd_data (ring_rd_data)
  );

  swmf_ram #(.WIDTH(WORD_W), .DEPTH(WINDOW_MAX)) u_sorted (
    .clk     (clk),
    .we      (srt_we),
    .wr_addr (srt_wr_addr),
    .wr_data (srt_wr_data),
    .rd_addr (srt_rd_addr),
    .rd_data (srt_rd_data)
  );

  assign status.idle = (state == S_IDLE);
  assign status.done = (state == S_OUT) && req.out_free;
  assign status.med  = srt_rd_data;
  assign status.held = held;

  a_held_le_cap: assert property (@(posedge clk) disable iff (rst)
    held <= cap) else $error("fill count above window size");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> state == S_IDLE) else $error("word started while busy");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> int'(scan) < int'(cap)) else $error("search past window");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    status.done |=> state == S_IDLE) else $error("no return to idle after result");

  a_held_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE) |-> held != '0) else $error("placing into empty window");

endmodule

`default_nettype wire

/* test/sliding_window_median_filter_core_tb.sv */
// Self-checking testbench for the sliding-window median filter core.

module sliding_window_median_filter_core_tb;
  import swmf_pkg::*;

  localparam int WIN_MAX = 16;
  localparam int SEGMENTS = 16;
  localparam int SEG_READINGS = 100;

  typedef struct packed {
    logic [DIST_W-1:0]  distance;
    logic [ANGLE_W-1:0] angle;
    logic [CNT_W-1:0]   count;
  } median_t;

  typedef enum logic {ROW_CFG, ROW_READING} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic [CNT_W-1:0] size;
    reading_t         rd;
    logic             known;
    median_t          want;
  } plan_row_t;

  localparam median_t NO_MEDIAN = '0;
  localparam reading_t NO_READING = '0;
  localparam int PLAN_ROWS = 32;

  // window sizes 0 and 17 to 31 clamp to 1 and 16; equal distances must not pass each other
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_READING, 5'd0, '{16'h1234, 16'h0001}, 1'b1, '{16'h1234, 16'h0001, 5'd1}},
    '{ROW_READING, 5'd0, '{16'hFFFF, 16'hFFFF}, 1'b1, '{16'hFFFF, 16'hFFFF, 5'd2}},
    '{ROW_READING, 5'd0, '{16'h0000, 16'h0000}, 1'b1, '{16'h1234, 16'h0001, 5'd3}},
    '{ROW_READING, 5'd0, '{16'h0100, 16'h0002}, 1'b0, NO_MEDIAN},
    '{ROW_CFG,     5'd1, NO_READING,            1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'hFFFF, 16'h0000}, 1'b1, '{16'hFFFF, 16'h0000, 5'd1}},
    '{ROW_READING, 5'd0, '{16'h0000, 16'hFFFF}, 1'b1, '{16'h0000, 16'hFFFF, 5'd1}},
    '{ROW_CFG,     5'd0, NO_READING,            1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h8000, 16'h5555}, 1'b1, '{16'h8000, 16'h5555, 5'd1}},
    '{ROW_READING, 5'd0, '{16'h7FFF, 16'hAAAA}, 1'b1, '{16'h7FFF, 16'hAAAA, 5'd1}},
    '{ROW_CFG,     5'd31, NO_READING,           1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0100, 16'h0001}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0100, 16'h0002}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0100, 16'h0003}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0100, 16'h0001}, 1'b0, NO_MEDIAN},
    '{ROW_CFG,     5'd2, NO_READING,            1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0050, 16'h0010}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0030, 16'h0011}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0070, 16'h0012}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0010, 16'h0013}, 1'b0, NO_MEDIAN},
    '{ROW_CFG,     5'd3, NO_READING,            1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0020, 16'h0001}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0020, 16'h0002}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0020, 16'h0003}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0010, 16'h0004}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0030, 16'h0005}, 1'b0, NO_MEDIAN},
    '{ROW_CFG,     5'd17, NO_READING,           1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0001, 16'h0001}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0003, 16'h0003}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0002, 16'h0002}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'hFFFF, 16'hFFFF}, 1'b0, NO_MEDIAN},
    '{ROW_READING, 5'd0, '{16'h0000, 16'h0000}, 1'b0, NO_MEDIAN}
  };

  localparam logic [CNT_W-1:0] SEG_SIZES [SEGMENTS] = '{
    5'd16, 5'd0, 5'd2, 5'd31, 5'd3, 5'd1, 5'd17, 5'd8,
    5'd16, 5'd5, 5'd15, 5'd4, 5'd16, 5'd7, 5'd31, 5'd9
  };

  logic             clk = 1'b0;
  logic             rst;
  logic             s_tvalid;
  logic             s_tready;
  logic [31:0]      s_tdata;   // distance, angle
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [39:0]      m_tdata;   // median_distance, median_angle, fill_count
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_wdata; // window_size

  // predictor state
  logic [CNT_W-1:0] win_size;
  reading_t         arrivals [WIN_MAX];
  reading_t         ordered [WIN_MAX];
  int               ring_pos;
  int               fill;

  median_t pending_medians [$];
  int      send_idle_pct;
  int      recv_stall_pct;
  int      errors;
  int      readings_sent;
  int      medians_checked;
  int      size_writes;

  sliding_window_median_filter_core #(.WINDOW_MAX(WIN_MAX)) DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_window(input logic [CNT_W-1:0] size);
    win_size = size;
    ring_pos = 0;
    fill = 0;
  endfunction

  // insert a reading, evicting the oldest once full, and return the median
  function automatic median_t advance_window(input reading_t r);
    int cap;
    int pos;
    int i;
    bit found;
    reading_t oldest;
    reading_t tmp;
    median_t m;
    cap = (win_size < 1) ? 1 : ((win_size > WIN_MAX) ? WIN_MAX : int'(win_size));
    if (ring_pos >= cap) ring_pos = 0;
    if (fill > cap) fill = cap;
    if (fill < cap) begin
      pos = fill;
      fill++;
    end else begin
      oldest = arrivals[ring_pos];
      pos = cap - 1;
      found = 1'b0;
      for (i = 0; i < cap && !found; i++) begin
        if (ordered[i] == oldest) begin
          pos = i;
          found = 1'b1;
        end
      end
    end
    arrivals[ring_pos] = r;
    ring_pos++;
    if (ring_pos >= cap) ring_pos = 0;
    ordered[pos] = r;
    while (pos > 0 && ordered[pos].distance < ordered[pos-1].distance) begin
      tmp = ordered[pos];
      ordered[pos] = ordered[pos-1];
      ordered[pos-1] = tmp;
      pos--;
    end
    while (pos + 1 < fill && ordered[pos].distance > ordered[pos+1].distance) begin
      tmp = ordered[pos];
      ordered[pos] = ordered[pos+1];
      ordered[pos+1] = tmp;
      pos++;
    end
    m.distance = ordered[(fill / 2) % WIN_MAX].distance;
    m.angle    = ordered[(fill / 2) % WIN_MAX].angle;
    m.count    = CNT_W'(fill);
    return m;
  endfunction

  // hold input until every median is out and the sequencer is idle
  task automatic drain_window();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_medians.size() != 0 || !s_tready) @(posedge clk);
  endtask

  task automatic write_size(input logic [CNT_W-1:0] size);
    drain_window();
    cfg_we    <= 1'b1;
    cfg_wdata <= size;
    @(posedge clk);
    cfg_we    <= 1'b0;
    clear_window(size);
    size_writes++;
  endtask

  task automatic push_reading(input reading_t r, input logic known, input median_t want);
    int gap;
    median_t m;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(6, 1);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {r.angle, r.distance};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    m = advance_window(r);
    pending_medians.push_back(known ? want : m);
    readings_sent++;
  endtask

  function automatic reading_t random_reading();
    reading_t r;
    case ($urandom_range(9))
      0:       r.distance = '0;
      1:       r.distance = '1;
      2, 3:    r.distance = DIST_W'($urandom_range(7));   // ties
      4:       r.distance = DIST_W'($urandom_range(16'hFFFF, 16'hFFF0));
      default: r.distance = DIST_W'($urandom);
    endcase
    // small angle pool so identical readings coexist in the window
    if ($urandom_range(3) == 0) r.angle = ANGLE_W'($urandom_range(3));
    else r.angle = ANGLE_W'($urandom);
    return r;
  endfunction

  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    median_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_medians.size() == 0) begin
        $error("median word %h with none expected", m_tdata);
        errors++;
      end else begin
        want = pending_medians.pop_front();
        medians_checked++;
        if (m_tdata[15:0] !== want.distance) begin
          $error("median_distance: expected %h, got %h", want.distance, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[31:16] !== want.angle) begin
          $error("median_angle: expected %h, got %h", want.angle, m_tdata[31:16]);
          errors++;
        end
        if (m_tdata[36:32] !== want.count) begin
          $error("fill_count: expected %0d, got %0d", want.count, m_tdata[36:32]);
          errors++;
        end
      end
    end
  end

  initial begin
    int row;
    int seg;
    int k;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    readings_sent = 0;
    medians_checked = 0;
    size_writes = 0;
    send_idle_pct  = 26;
    recv_stall_pct = 45;
    clear_window(WSIZE_RESET);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < PLAN_ROWS; row++) begin
      if (PLAN[row].kind == ROW_CFG) write_size(PLAN[row].size);
      else push_reading(PLAN[row].rd, PLAN[row].known, PLAN[row].want);
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      if (seg < 5) begin
        send_idle_pct  = 26;
        recv_stall_pct = 45;
      end else if (seg < 10) begin
        send_idle_pct  = 45;
        recv_stall_pct = 26;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_size(SEG_SIZES[seg]);
      for (k = 0; k < SEG_READINGS; k++) begin
        if (k == SEG_READINGS / 2) drain_window();
        push_reading(random_reading(), 1'b0, NO_MEDIAN);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_medians.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Checked %0d medians from %0d readings over %0d window size writes,",
             medians_checked, readings_sent, size_writes);
    $display("window sizes 0..31 with ties, saturated distances and random stalls");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timed out with %0d medians outstanding", pending_medians.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
